// ----- rtl/core/date_difference_days_assert.svh -----
// Assertion macros shared by the date difference RTL.
`ifndef DATE_DIFFERENCE_DAYS_ASSERT_SVH
`define DATE_DIFFERENCE_DAYS_ASSERT_SVH

`ifndef ASSERT_OFF

// Implication checked at every rising edge of clk outside reset.
`define DD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never hold at a rising edge of clk outside reset.
`define DD_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define DD_ASSERT(label, prop, msg)
`define DD_NEVER(label, cond, msg)

`endif

`endif

// ----- rtl/core/ddays_pkg.sv -----
// Types, constants and calendar helper functions for the date difference block.
package ddays_pkg;

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int COUNT_W = 22;

    localparam int MAX_YEAR    = 9999;
    localparam int MONTH_FIRST = 1;
    localparam int MONTH_LAST  = 12;
    localparam int MONTH_FEB   = 2;

    // Quotients by 100 and 400 through a reciprocal multiply, exact for any 14-bit dividend.
    localparam int RECIP_W    = 14;
    localparam int PROD_W     = YEAR_W + RECIP_W;
    localparam int SHIFT_C    = 20;
    localparam int SHIFT_Q    = 22;
    localparam int Q100_W     = 8;
    localparam int Q400_W     = 6;
    localparam int LEAPS_W    = 12;
    localparam int MSTART_W   = 9;

    localparam logic [RECIP_W-1:0] RECIP_100 = RECIP_W'(((1 << SHIFT_C) + 99) / 100);
    localparam logic [RECIP_W-1:0] RECIP_400 = RECIP_W'(((1 << SHIFT_Q) + 399) / 400);

    typedef logic [YEAR_W-1:0]   year_t;
    typedef logic [MONTH_W-1:0]  month_t;
    typedef logic [DAY_W-1:0]    day_t;
    typedef logic [COUNT_W-1:0]  count_t;
    typedef logic [Q100_W-1:0]   q100_t;
    typedef logic [Q400_W-1:0]   q400_t;
    typedef logic [MSTART_W-1:0] mstart_t;

    typedef struct packed {
        year_t  year;
        month_t month;
        day_t   day;
    } date_t;

    // Quotients and year-length product for one date.
    typedef struct packed {
        date_t  date;
        count_t year_days;
        q100_t  cent_up;
        q400_t  quad_up;
        q100_t  cent_dn;
        q400_t  quad_dn;
    } yparts_t;

    function automatic year_t clamp_year(input year_t y);
        clamp_year = (y > YEAR_W'(MAX_YEAR)) ? YEAR_W'(MAX_YEAR) : y;
    endfunction

    function automatic month_t clamp_month(input month_t m);
        if (m < MONTH_W'(MONTH_FIRST))
        begin
            clamp_month = MONTH_W'(MONTH_FIRST);
        end
        else if (m > MONTH_W'(MONTH_LAST))
        begin
            clamp_month = MONTH_W'(MONTH_LAST);
        end
        else
        begin
            clamp_month = m;
        end
    endfunction

    // Days in the months before month m of a common year.
    function automatic mstart_t month_start(input month_t m);
        case (m)
            4'd1:    month_start = 9'd0;
            4'd2:    month_start = 9'd31;
            4'd3:    month_start = 9'd59;
            4'd4:    month_start = 9'd90;
            4'd5:    month_start = 9'd120;
            4'd6:    month_start = 9'd151;
            4'd7:    month_start = 9'd181;
            4'd8:    month_start = 9'd212;
            4'd9:    month_start = 9'd243;
            4'd10:   month_start = 9'd273;
            4'd11:   month_start = 9'd304;
            4'd12:   month_start = 9'd334;
            default: month_start = 9'd0;
        endcase
    endfunction

endpackage

// ----- rtl/core/date_difference_days.sv -----
// Throughput: one date pair per cycle while rsp_stall is low; each stage holds one
// transaction and moves on whenever the stage after it is empty or moving, so bubbles are squeezed out.
// The critical path is the 14 by 14 bit reciprocal multiply in the second stage.
// Reset (rst_n, asynchronous, active low) empties every stage; payload is not reset.
module date_difference_days
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    output logic                   req_stall,
    input  ddays_pkg::year_t       first_year,
    input  ddays_pkg::month_t      first_month,
    input  ddays_pkg::day_t        first_day,
    input  ddays_pkg::year_t       second_year,
    input  ddays_pkg::month_t      second_month,
    input  ddays_pkg::day_t        second_day,
    output logic                   rsp_valid,
    input  logic                   rsp_stall,
    output ddays_pkg::count_t      day_count,
    output logic                   order_error
);

    import ddays_pkg::*;

    // Stage valid bits, one per register stage, cleared by reset.
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic v1_next, v2_next, v3_next, v4_next;

    // Stage enables: a stage loads when it is empty or its contents move on.
    logic en1, en2, en3, en4;

    // Stage one: saturated dates and the order comparison.
    date_t  s1_reg [2];
    date_t  s1_next [2];
    logic   late1_reg, late1_next;

    // Stage two: reciprocal quotients and the whole-year product.
    yparts_t s2_reg [2];
    yparts_t s2_next [2];
    logic    late2_reg, late2_next;

    // Stage three: day numbers counted from the start of year zero.
    count_t n3_reg [2];
    count_t n3_next [2];
    logic   late3_reg, late3_next;

    // Stage four: the result register facing the output channel.
    count_t count_reg, count_next;
    logic   err_reg, err_next;

    assign en4 = !v4_reg || !rsp_stall;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;

    assign req_stall = !en1;

    assign v1_next = en1 ? req_valid : v1_reg;
    assign v2_next = en2 ? v1_reg    : v2_reg;
    assign v3_next = en3 ? v2_reg    : v3_reg;
    assign v4_next = en4 ? v3_reg    : v4_reg;

    // Stage one: clamp out-of-range years and months, then compare the pairs in
    // year, month, day order. Concatenation makes the comparison lexicographic.
    always_comb
    begin
        s1_next[0].year  = clamp_year(first_year);
        s1_next[0].month = clamp_month(first_month);
        s1_next[0].day   = first_day;
        s1_next[1].year  = clamp_year(second_year);
        s1_next[1].month = clamp_month(second_month);
        s1_next[1].day   = second_day;
        late1_next = {s1_next[0].year, s1_next[0].month, s1_next[0].day}
                   > {s1_next[1].year, s1_next[1].month, s1_next[1].day};
    end

    // Stage two: the ceiling quotients by 100 and 400 count the century and
    // quadricentennial leap-year corrections for the years before this one; the
    // floor quotients of the year itself feed the leap test of the year.
    always_comb
    begin
        logic [PROD_W-1:0] prod_cu;
        logic [PROD_W-1:0] prod_qu;
        logic [PROD_W-1:0] prod_cd;
        logic [PROD_W-1:0] prod_qd;
        for (int i = 0; i < 2; i++)
        begin
            prod_cu = PROD_W'(s1_reg[i].year + YEAR_W'(99)) * PROD_W'(RECIP_100);
            prod_qu = PROD_W'(s1_reg[i].year + YEAR_W'(399)) * PROD_W'(RECIP_400);
            prod_cd = PROD_W'(s1_reg[i].year) * PROD_W'(RECIP_100);
            prod_qd = PROD_W'(s1_reg[i].year) * PROD_W'(RECIP_400);
            s2_next[i].date      = s1_reg[i];
            s2_next[i].year_days = COUNT_W'(s1_reg[i].year) * COUNT_W'(365);
            s2_next[i].cent_up   = prod_cu[SHIFT_C +: Q100_W];
            s2_next[i].quad_up   = prod_qu[SHIFT_Q +: Q400_W];
            s2_next[i].cent_dn   = prod_cd[SHIFT_C +: Q100_W];
            s2_next[i].quad_dn   = prod_qd[SHIFT_Q +: Q400_W];
        end
        late2_next = late1_reg;
    end

    // Stage three: whole years, leap days before the year, days before the
    // month, the extra day of February in a leap year and the day as given.
    always_comb
    begin
        logic [LEAPS_W-1:0] leaps;
        logic               is_leap;
        logic               mult4;
        logic               mult100;
        logic               mult400;
        for (int i = 0; i < 2; i++)
        begin
            leaps   = LEAPS_W'((s2_reg[i].date.year + YEAR_W'(3)) >> 2)
                    - LEAPS_W'(s2_reg[i].cent_up) + LEAPS_W'(s2_reg[i].quad_up);
            mult4   = (s2_reg[i].date.year[1:0] == 2'b00);
            mult100 = (s2_reg[i].date.year == YEAR_W'(s2_reg[i].cent_dn) * YEAR_W'(100));
            mult400 = (s2_reg[i].date.year == YEAR_W'(s2_reg[i].quad_dn) * YEAR_W'(400));
            is_leap = mult4 && (!mult100 || mult400);
            n3_next[i] = s2_reg[i].year_days + COUNT_W'(leaps)
                       + COUNT_W'(month_start(s2_reg[i].date.month))
                       + COUNT_W'(s2_reg[i].date.day)
                       + COUNT_W'(is_leap && (s2_reg[i].date.month > MONTH_W'(MONTH_FEB)));
        end
        late3_next = late2_reg;
    end

    // Stage four: the span, held at zero when the dates are out of order or
    // when unchecked day numbers make the earlier date's number the larger.
    always_comb
    begin
        if (late3_reg || (n3_reg[1] <= n3_reg[0]))
        begin
            count_next = '0;
        end
        else
        begin
            count_next = n3_reg[1] - n3_reg[0];
        end
        err_next = late3_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            v4_reg <= v4_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_reg    <= s1_next;
            late1_reg <= late1_next;
        end
        if (en2)
        begin
            s2_reg    <= s2_next;
            late2_reg <= late2_next;
        end
        if (en3)
        begin
            n3_reg    <= n3_next;
            late3_reg <= late3_next;
        end
        if (en4)
        begin
            count_reg <= count_next;
            err_reg   <= err_next;
        end
    end

    assign rsp_valid   = v4_reg;
    assign day_count   = count_reg;
    assign order_error = err_reg;

`include "date_difference_days_assert.svh"

    // An out-of-order pair must never report a non-zero span.
    `DD_NEVER(a_err_zero, rsp_valid && order_error && (day_count != '0), "order error with non-zero count")
    // The input side stalls only when every stage holds a transaction.
    `DD_ASSERT(a_stall_full, req_stall |-> (v1_reg && v2_reg && v3_reg && v4_reg), "stall with an empty stage")
    // An accepted transaction always lands in the first stage.
    `DD_ASSERT(a_accept_load, (req_valid && !req_stall) |=> v1_reg, "accepted transaction lost")
    // The order flag reaches the output with the transaction that raised it.
    `DD_ASSERT(a_err_follow, (v3_reg && late3_reg && en4) |=> (rsp_valid && order_error), "order flag dropped")

endmodule
